[src/base64_custom_alphabet_decoder_macros.svh]
// Assertion macros for the decoder RTL, used by b64d_emit.
// Expects signals named clock and reset in the module that uses them.
`ifndef BASE64_CUSTOM_ALPHABET_DECODER_MACROS_SVH
`define BASE64_CUSTOM_ALPHABET_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64D_CHECK_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64D_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[src/b64d_pkg.sv]
// Shared types, character constants and the alphabet lookup for the decoder.
// No dependencies.
package b64d_pkg;

   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
   localparam logic [7:0] CHAR_DIG_0 = 8'h30;
   localparam logic [7:0] CHAR_DIG_9 = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_UNDER = 8'h5f;

   localparam logic [5:0] DIGIT_BASE = 6'd26;
   localparam logic [5:0] UPPER_BASE = 6'd36;
   localparam logic [5:0] DASH_CODE  = 6'd62;
   localparam logic [5:0] UNDER_CODE = 6'd63;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_of_text;
   } rsp_item_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Results caused by one input item: up to three bytes, sent in order.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            byte_valid;
      logic            last;
   } group_type;

   function automatic sextet_type sextet_lookup(input logic [7:0] c);
      sextet_type r;
      r.ok    = 1'b1;
      r.value = '0;
      priority if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         r.value = 6'(c - CHAR_LC_A);
      end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
         r.value = 6'(c - CHAR_DIG_0) + DIGIT_BASE;
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         r.value = 6'(c - CHAR_UC_A) + UPPER_BASE;
      end else if (c == CHAR_DASH) begin
         r.value = DASH_CODE;
      end else if (c == CHAR_UNDER) begin
         r.value = UNDER_CODE;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[src/b64d_chan_if.sv]
// Valid/ready channel carrying one item of a parameter payload type.
// Used with the item types of b64d_pkg.
interface b64d_chan_if #(parameter type item_type = logic);
   logic     valid;
   logic     ready;
   item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/b64d_core.sv]
// Decode stage: alphabet lookup, sextet buffer, halt flag and byte assembly.
// Depends on b64d_pkg and b64d_chan_if; hands result groups to b64d_emit.
module b64d_core
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64d_chan_if.sink  req_chan,
   input  logic       grp_ready,
   output logic       grp_load,
   output group_type  grp
);

   logic [2:0][5:0] buf_ff, buf_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            halted_ff, halted_in;
   logic            full;
   logic            need_grp;
   logic            accept;
   sextet_type      lk;

   // Only an item that causes results has to wait for the serializer.
   assign need_grp       = full || req_chan.payload.end_of_text;
   assign req_chan.ready = grp_ready || !need_grp;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      lk        = sextet_lookup(req_chan.payload.char_code);
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      halted_in = halted_ff;
      full      = 1'b0;
      if (!halted_ff) begin
         if (!lk.ok) begin
            halted_in = 1'b1;
         end else if (cnt_ff == 2'd3) begin
            full   = 1'b1;
            cnt_in = 2'd0;
         end else begin
            buf_in[cnt_ff] = lk.value;
            cnt_in         = cnt_ff + 2'd1;
         end
      end
   end

   // Buffer is unchanged on a full group, so both cases read buf_in.
   always_comb begin
      grp.bytes[0]   = {buf_in[0], buf_in[1][5:4]};
      grp.bytes[1]   = {buf_in[1][3:0], buf_in[2][5:2]};
      grp.bytes[2]   = {buf_in[2][1:0], lk.value};
      grp.last       = req_chan.payload.end_of_text;
      grp.byte_valid = full || (cnt_in >= 2'd2);
      if (full) begin
         grp.last_idx = 2'd2;
      end else if (cnt_in >= 2'd2) begin
         grp.last_idx = cnt_in - 2'd2;
      end else begin
         grp.last_idx = 2'd0;
      end
   end

   assign grp_load = accept && need_grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         if (req_chan.payload.end_of_text) begin
            cnt_ff    <= 2'd0;
            halted_ff <= 1'b0;
         end else begin
            cnt_ff    <= cnt_in;
            halted_ff <= halted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
   end

endmodule

[src/b64d_emit.sv]
// Result register and serializer: sends the bytes of one group, one per item.
// Depends on b64d_pkg, b64d_chan_if and the decoder macros header.
`include "base64_custom_alphabet_decoder_macros.svh"

module b64d_emit
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        grp_load,
   input  group_type   grp,
   output logic        grp_ready,
   b64d_chan_if.source rsp_chan
);

   group_type  grp_ff;
   logic       grp_valid_ff;
   logic [1:0] idx_ff;
   logic       at_end;
   logic       rsp_accept;

   assign at_end     = (idx_ff == grp_ff.last_idx);
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;
   assign grp_ready  = !grp_valid_ff || (rsp_chan.ready && at_end);

   assign rsp_chan.valid                = grp_valid_ff;
   assign rsp_chan.payload.data_byte    = grp_ff.byte_valid ? grp_ff.bytes[idx_ff] : 8'd0;
   assign rsp_chan.payload.byte_valid   = grp_ff.byte_valid;
   assign rsp_chan.payload.last_of_text = grp_ff.last && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (grp_load) begin
         grp_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (rsp_accept) begin
         if (at_end) begin
            grp_valid_ff <= 1'b0;
            idx_ff       <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_ff <= grp;
      end
   end

   `B64D_CHECK_SAME(a_idx_in_group, rsp_chan.valid, idx_ff <= grp_ff.last_idx)
   `B64D_CHECK_SAME(a_empty_is_last, rsp_chan.valid && !grp_ff.byte_valid,
                    rsp_chan.payload.last_of_text && grp_ff.last_idx == 2'd0)
   `B64D_CHECK_NEXT(a_hold_midgroup, rsp_accept && !at_end, rsp_chan.valid && idx_ff != 2'd0)
   `B64D_CHECK_NEXT(a_load_starts, grp_load, grp_valid_ff && idx_ff == 2'd0)

endmodule

[src/base64_custom_alphabet_decoder.sv]
// Result: the first result of an item is registered and offered in the cycle after the item is accepted.
// Throughput: one item per cycle; an item that causes results waits until the previous
//   group is on its last byte and rsp_chan is ready, one byte per cycle while ready;
//   no-result items pass: a group of three drains under the next three chars, no stall.
// Reset: synchronous, active high; clears sextet count, halt flag and the pending result.
// Depends on b64d_pkg, b64d_chan_if, b64d_core and b64d_emit.
module base64_custom_alphabet_decoder
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64d_chan_if.sink   req_chan,
   b64d_chan_if.source rsp_chan
);

   // Group handoff between the decode stage and the result serializer.
   group_type grp;
   logic      grp_load;
   logic      grp_ready;

   // Decode stage: look up the character, collect sextets, build the bytes that
   // this item causes, and hold such an item only until the serializer can take it.
   b64d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .grp_ready (grp_ready),
      .grp_load  (grp_load),
      .grp       (grp)
   );

   // Result register: hold one group and send its bytes in order; the last one
   // of a string carries last_of_text. A new group loads as the old one drains.
   b64d_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .grp_load  (grp_load),
      .grp       (grp),
      .grp_ready (grp_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
